FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on i_clk with i_rst_n low masking the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LJ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ljpe_pkg.sv
`default_nettype none
package ljpe_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int DEF_INDEX_BITS = 16;
    localparam int IN_DATA_W      = 272;
    localparam int OUT_DATA_W     = 272;

    localparam logic [62:0] CAP_VAL = 63'h4000_0000_0000_0000;
    localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN = 48'h8000_0000_0000;

    // right shift applied to a finished product
    typedef enum logic [1:0] {
        SH_NONE,
        SH_WORD,
        SH_FRAC
    } t_shift;

    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_ctl;

    typedef struct packed {
        logic done;
        logic cap;
    } t_unit_stat;

endpackage
`default_nettype wire

FILE: rtl/ljpe_mul.sv
`default_nettype none
// 64x64 multiply on one 32x32 multiplier, four partial products,
// result shifted and capped at 2^62.
module ljpe_mul
    import ljpe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mul_ctl    i_ctl,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output t_unit_stat       o_stat,
    output logic [62:0]      o_res
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_pp_vld;
    logic         r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic [127:0] r_acc;
    t_shift       r_shift;

    logic [31:0]  w_opa;
    logic [31:0]  w_opb;
    logic [127:0] w_pp_pos;
    logic [127:0] w_sh;
    logic         w_cap;

    assign w_opa = r_cnt[1] ? i_a[63:32] : i_a[31:0];
    assign w_opb = r_cnt[0] ? i_b[63:32] : i_b[31:0];

    always_comb begin
        unique case (r_pp_sh)
            2'd0:    w_pp_pos = {64'd0, r_pp};
            2'd1:    w_pp_pos = {32'd0, r_pp, 32'd0};
            2'd2:    w_pp_pos = {r_pp, 64'd0};
            default: w_pp_pos = '0;
        endcase
    end

    always_comb begin
        unique case (r_shift)
            SH_NONE: w_sh = r_acc;
            SH_WORD: w_sh = r_acc >> 32;
            SH_FRAC: w_sh = r_acc >> FRAC_BITS;
            default: w_sh = r_acc;
        endcase
    end

    assign w_cap  = (|w_sh[127:63]) | (w_sh[62] & (|w_sh[61:0]));
    assign o_res  = w_cap ? CAP_VAL : w_sh[62:0];
    assign o_stat = '{done: r_done, cap: w_cap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt < 3'd4) begin
                    r_pp_vld <= 1'b1;
                    r_cnt    <= r_cnt + 3'd1;
                end else if (!r_pp_vld) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc   <= '0;
            r_shift <= i_ctl.shift;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + w_pp_pos;
        end
        if (r_busy && r_cnt < 3'd4) begin
            r_pp    <= 64'(w_opa) * 64'(w_opb);
            r_pp_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ljpe_div.sv
`default_nettype none
// floor(num * 2^32 / den), restoring, one quotient bit per cycle, capped at 2^62.
module ljpe_div
    import ljpe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [61:0] i_den,
    output t_unit_stat       o_stat,
    output logic [62:0]      o_res
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [61:0] r_rem;
    logic [95:0] r_q;

    logic [62:0] w_trial;
    logic [62:0] w_diff;
    logic        w_ge;
    logic        w_cap;

    assign w_trial = {r_rem, r_q[95]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};

    assign w_cap  = (|r_q[95:63]) | (r_q[62] & (|r_q[61:0]));
    assign o_res  = w_cap ? CAP_VAL : r_q[62:0];
    assign o_stat = '{done: r_done, cap: w_cap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd95;
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_num, 32'd0};
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[94:0], w_ge};
            r_rem <= w_ge ? w_diff[61:0] : w_trial[61:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lj_pair_energy_gradient.sv
// Channel   Dir  tdata (low bit up)                                  tuser   tlast
// s_axis    in   index_a, index_b, pos_a_xyz, pos_b_xyz, sigma, eps  mode    last_pair
// m_axis    out  index_a, index_b, grad_xyz, pair_energy, total      satur.  last_out
//
// One pair at a time: gradient mode takes longer than energy only, and far,
// zero-distance or zero-epsilon pairs finish sooner.
// The shared divider sets the pace, run for t2 and, in gradient mode, again for
// the gradient; the multiplies share one 32x32 multiplier.
// s_axis_tready is high only while no pair is in work; a finished result waits
// in the output register and the next pair may be taken meanwhile.
// Synchronous active-low reset clears control and the running energy sum.
`default_nettype none
`include "assert_macros.svh"
module lj_pair_energy_gradient
    import ljpe_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // index_a, index_b, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // pair_sigma, pair_epsilon
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_index_a, out_index_b, grad_x, grad_y, grad_z, pair_energy, energy_total
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // saturated
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int IW  = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int ESH = 30 - FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_R2, S_S2, S_CLS, S_T2, S_T4, S_T6,
        S_U, S_P, S_EN, S_H, S_G, S_FIN
    } t_state;

    t_state             r_state;
    logic               r_issued;
    logic [1:0]         r_c;
    logic               r_mode;
    logic               r_last;
    logic [IW-1:0]      r_idx_a;
    logic [IW-1:0]      r_idx_b;
    logic signed [32:0] r_d [3];
    logic [23:0]        r_sigma;
    logic [23:0]        r_eps;
    logic [61:0]        r_r2;
    logic [47:0]        r_s2;
    logic [62:0]        r_t2;
    logic [62:0]        r_t6;
    logic [62:0]        r_u;
    logic [62:0]        r_p;
    logic [63:0]        r_dd;
    logic [62:0]        r_h;
    logic               r_hsat;
    logic               r_osat;
    logic               r_sat;
    logic signed [47:0] r_e;
    logic signed [47:0] r_g [3];
    logic signed [47:0] r_sum;
    logic               r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic               r_o_sat;
    logic               r_o_last;

    t_mul_ctl    w_mctl;
    logic        w_mstart;
    t_shift      w_mshift;
    t_unit_stat  w_mstat;
    t_unit_stat  w_dstat;
    logic [62:0] w_mres;
    logic [62:0] w_dres;
    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic [63:0] w_dnum;
    logic        w_dstart;

    logic [32:0] w_ad [3];
    logic [32:0] w_ad_c;
    logic signed [32:0] w_d_c;
    logic [37:0] w_ad24;
    logic        w_far;
    logic        w_dpos;
    logic        w_ddpos;
    logic        w_gneg;
    logic        w_g_need;
    logic [63:0] w_mag;
    logic [63:0] w_dd;
    logic signed [63:0] w_es;
    logic [48:0] w_ecl;
    logic [48:0] w_tot;
    logic [48:0] w_gm;
    logic [48:0] w_gcap;
    logic        w_over_cls;

    function automatic logic [48:0] f_clamp48(input logic signed [63:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF) return {1'b1, OUT_MAX};
        if (x < 64'shFFFF_8000_0000_0000) return {1'b1, OUT_MIN};
        return {1'b0, x[47:0]};
    endfunction

    // signed gradient from magnitude, clamped to 48 bits
    function automatic logic [48:0] f_gclamp(input logic [62:0] m, input logic neg);
        if (!neg) begin
            if (m > 63'h7FFF_FFFF_FFFF) return {1'b1, OUT_MAX};
            return {1'b0, m[47:0]};
        end
        if (m > 63'h8000_0000_0000) return {1'b1, OUT_MIN};
        return {1'b0, ~m[47:0] + 48'd1};
    endfunction

    function automatic logic [47:0] f_over_g(input logic signed [32:0] d);
        if (d > 33'sd0) return OUT_MIN;
        if (d < 33'sd0) return OUT_MAX;
        return '0;
    endfunction

    for (genvar c = 0; c < 3; c++) begin : g_abs
        assign w_ad[c] = r_d[c][32] ? 33'(-r_d[c]) : 33'(r_d[c]);
    end

    always_comb begin
        unique case (r_c)
            2'd0:    begin w_ad_c = w_ad[0]; w_d_c = r_d[0]; end
            2'd1:    begin w_ad_c = w_ad[1]; w_d_c = r_d[1]; end
            2'd2:    begin w_ad_c = w_ad[2]; w_d_c = r_d[2]; end
            default: begin w_ad_c = '0;      w_d_c = '0;     end
        endcase
    end

    assign w_far    = (|w_ad[0][32:30]) | (|w_ad[1][32:30]) | (|w_ad[2][32:30]);
    assign w_ad24   = {1'b0, w_ad_c, 4'd0} + {2'd0, w_ad_c, 3'd0};
    assign w_dpos   = !w_d_c[32] && (|w_d_c);
    assign w_ddpos  = !r_dd[63] && (|r_dd);
    assign w_gneg   = (w_ddpos == w_dpos);
    assign w_g_need = (|w_ad_c) && (|r_dd) && !r_hsat;
    assign w_mag    = r_dd[63] ? (~r_dd + 64'd1) : r_dd;
    // wraps at 64 bits when 2p reaches 2^63
    assign w_dd     = {r_p, 1'b0} - {1'b0, r_u};
    assign w_es     = $signed({1'b0, r_p} >> ESH) - $signed({1'b0, r_u} >> ESH);
    assign w_ecl    = f_clamp48(w_es);
    assign w_tot    = f_clamp48(64'(r_sum) + 64'(r_e));
    assign w_gm     = f_gclamp(w_mres, w_gneg);
    assign w_gcap   = f_gclamp(CAP_VAL, w_gneg);
    assign w_over_cls = (r_r2[61:56] == 6'd0) && ({16'd0, r_s2} >= {r_r2[55:0], 8'd0});

    // operand select for the shared multiplier
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mshift = SH_WORD;
        unique case (r_state)
            S_R2: begin
                w_ma = {31'd0, w_ad_c};
                w_mb = {31'd0, w_ad_c};
                w_mshift = SH_NONE;
            end
            S_S2: begin
                w_ma = {40'd0, r_sigma};
                w_mb = {40'd0, r_sigma};
                w_mshift = SH_NONE;
            end
            S_T4: begin w_ma = {1'b0, r_t2}; w_mb = {1'b0, r_t2}; end
            S_T6: begin w_ma = {1'b0, r_t6}; w_mb = {1'b0, r_t2}; end
            S_U: begin
                w_ma = {40'd0, r_eps};
                w_mb = {1'b0, r_t6};
                w_mshift = SH_FRAC;
            end
            S_P: begin w_ma = {1'b0, r_u}; w_mb = {1'b0, r_t6}; end
            S_G: begin w_ma = {1'b0, r_h}; w_mb = {26'd0, w_ad24}; end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_R2, S_S2, S_T4, S_T6, S_U, S_P: w_mstart = !r_issued;
            S_G:     w_mstart = !r_issued && w_g_need;
            default: w_mstart = 1'b0;
        endcase
    end

    assign w_mctl = '{start: w_mstart, shift: w_mshift};

    assign w_dstart = ((r_state == S_T2) || (r_state == S_H)) && !r_issued;
    assign w_dnum   = (r_state == S_T2) ? {16'd0, r_s2} : w_mag;

    ljpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_stat  (w_mstat),
        .o_res   (w_mres)
    );

    ljpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (r_r2),
        .o_stat  (w_dstat),
        .o_res   (w_dres)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_sat;
    assign m_axis_tlast  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issued  <= 1'b0;
            r_c       <= '0;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // S_FIN owns the valid flag while it loads a new beat
            if (r_o_valid && m_axis_tready && (r_state != S_FIN)) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode   <= s_axis_tuser;
                        r_last   <= s_axis_tlast;
                        r_idx_a  <= s_axis_tdata[IW-1:0];
                        r_idx_b  <= s_axis_tdata[16 +: IW];
                        r_d[0]   <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
                                  - $signed({s_axis_tdata[159], s_axis_tdata[159:128]});
                        r_d[1]   <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
                                  - $signed({s_axis_tdata[191], s_axis_tdata[191:160]});
                        r_d[2]   <= $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
                                  - $signed({s_axis_tdata[223], s_axis_tdata[223:192]});
                        r_sigma  <= s_axis_tdata[247:224];
                        r_eps    <= s_axis_tdata[271:248];
                        r_sat    <= 1'b0;
                        r_osat   <= 1'b0;
                        r_hsat   <= 1'b0;
                        r_e      <= '0;
                        r_g[0]   <= '0;
                        r_g[1]   <= '0;
                        r_g[2]   <= '0;
                        r_r2     <= '0;
                        r_c      <= '0;
                        r_issued <= 1'b0;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= w_far ? S_FIN : S_R2;
                end
                S_R2: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mstat.done) begin
                        r_issued <= 1'b0;
                        r_r2     <= r_r2 + w_mres[61:0];
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_S2;
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                S_S2: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mstat.done) begin
                        r_issued <= 1'b0;
                        r_s2     <= w_mres[47:0];
                        r_state  <= S_CLS;
                    end
                end
                S_CLS: begin
                    priority if (r_r2 == '0) begin
                        r_sat   <= 1'b1;
                        r_e     <= (r_eps != '0) ? OUT_MAX : '0;
                        r_state <= S_FIN;
                    end else if (r_eps == '0) begin
                        r_state <= S_FIN;
                    end else if (w_over_cls) begin
                        r_sat   <= 1'b1;
                        r_e     <= OUT_MAX;
                        r_g[0]  <= r_mode ? f_over_g(r_d[0]) : '0;
                        r_g[1]  <= r_mode ? f_over_g(r_d[1]) : '0;
                        r_g[2]  <= r_mode ? f_over_g(r_d[2]) : '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_dstat.done) begin
                        r_issued <= 1'b0;
                        r_t2     <= w_dres;
                        if (w_dstat.cap) r_sat <= 1'b1;
                        r_state  <= S_T4;
                    end
                end
                S_T4, S_T6, S_U, S_P: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mstat.done) begin
                        r_issued <= 1'b0;
                        if (w_mstat.cap) r_osat <= 1'b1;
                        unique case (r_state)
                            S_T4:    begin r_t6 <= w_mres; r_state <= S_T6; end
                            S_T6:    begin r_t6 <= w_mres; r_state <= S_U;  end
                            S_U:     begin r_u  <= w_mres; r_state <= S_P;  end
                            default: begin r_p  <= w_mres; r_state <= S_EN; end
                        endcase
                    end
                end
                S_EN: begin
                    if (r_osat) begin
                        r_sat   <= 1'b1;
                        r_e     <= OUT_MAX;
                        r_g[0]  <= r_mode ? f_over_g(r_d[0]) : '0;
                        r_g[1]  <= r_mode ? f_over_g(r_d[1]) : '0;
                        r_g[2]  <= r_mode ? f_over_g(r_d[2]) : '0;
                        r_state <= S_FIN;
                    end else begin
                        r_e  <= w_ecl[47:0];
                        r_dd <= w_dd;
                        if (w_ecl[48]) r_sat <= 1'b1;
                        r_state <= r_mode ? S_H : S_FIN;
                    end
                end
                S_H: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_dstat.done) begin
                        r_issued <= 1'b0;
                        r_h      <= w_dres;
                        r_hsat   <= w_dstat.cap;
                        if (w_dstat.cap) r_sat <= 1'b1;
                        r_c      <= '0;
                        r_state  <= S_G;
                    end
                end
                S_G: begin
                    // one axis per pass; the multiplier only when the product matters
                    if (!r_issued && w_g_need) begin
                        r_issued <= 1'b1;
                    end else if (!r_issued || w_mstat.done) begin
                        r_issued <= 1'b0;
                        if (!r_issued && !((|w_ad_c) && (|r_dd))) begin
                            r_g[r_c] <= '0;
                        end else if (!r_issued) begin
                            r_g[r_c] <= w_gcap[47:0];
                            if (w_gcap[48]) r_sat <= 1'b1;
                        end else begin
                            r_g[r_c] <= w_gm[47:0];
                            if (w_gm[48] || w_mstat.cap) r_sat <= 1'b1;
                        end
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {w_tot[47:0], r_e, r_g[2], r_g[1], r_g[0],
                                      16'(r_idx_b), 16'(r_idx_a)};
                        r_o_sat   <= r_sat | w_tot[48];
                        r_o_last  <= r_last;
                        r_sum     <= r_last ? '0 : $signed(w_tot[47:0]);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LJ_ASSERT_SAME(a_div_owner, w_dstat.done, (r_state == S_T2) || (r_state == S_H), "divider result outside its states")
    `LJ_ASSERT_SAME(a_mul_owner, w_mstat.done, r_issued, "multiplier result with no request")
    `LJ_ASSERT_NEXT(a_one_pair, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while a pair is in work")
    `LJ_ASSERT_NEXT(a_sum_clear, m_axis_tvalid && m_axis_tlast && (r_state == S_IDLE) && !s_axis_tvalid, r_sum == '0, "energy sum kept after last pair")

endmodule
`default_nettype wire
